/* rtl/brchs_pkg.sv */
// shared types and constants for the bitmap rectangle hit scanner
package brchs_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_KEY_COLOR    = 2'd0;
    localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd1;
    localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd2;

    // request fields
    localparam int PIX_COORD_W = 8;
    localparam int VALUE_W     = 32;
    localparam int RECT_W      = 16;
    localparam int SIZE_W      = 9;
    localparam int ROW_OUT_W   = 8;

    // internal width for clipped coordinates, one bit over a rect edge
    localparam int CLIP_W = RECT_W + 1;
    // width that holds any saturated image size
    localparam int SAT_W  = 13;

    typedef logic signed [CLIP_W-1:0] clip_t;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // reset values of the configuration registers
    localparam logic [VALUE_W-1:0] KEY_COLOR_RST = 32'h00FF_00FF;
    localparam logic [SIZE_W-1:0]  SIZE_RST      = 9'd256;

endpackage

/* rtl/brchs_ram.sv */
// generic single-write, single-read RAM with registered read data
module brchs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/bitmap_rect_color_hit_scan_core.sv */
// top level: pixel mask store and rectangle key-color hit scanner
//
//  channel   direction  handshake          payload
//  cfg       in         cfg_wr_en          cfg_index, cfg_data
//  s_        in         s_valid / s_ready  action, pixel_x/y, pixel_value, rect edges
//  m_        out        m_valid / m_ready  hit, hit_row
//
// a load request writes an in-range pixel to the mask RAM on accept. a query latches
// its clipped rectangle; ST_SCAN reads and compares the pixels up to and including the
// first hit; one RAM read per cycle sets the scan pace. an empty one ends in ST_START.
// reset clears control state and the kept hit row; mask contents survive reset.
// the result sits in an output register; a new request is taken while it waits,
// and a query only stalls at its last step if the previous result is still untaken.
module bitmap_rect_color_hit_scan_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int COLOR_BITS = 32
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // configuration
    input  logic                                      cfg_wr_en,
    input  brchs_pkg::cfg_idx_t                       cfg_index,
    input  logic [brchs_pkg::CFG_DATA_W-1:0]          cfg_data,
    // request channel
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic                                      s_action,
    input  logic [brchs_pkg::PIX_COORD_W-1:0]         s_pixel_x,
    input  logic [brchs_pkg::PIX_COORD_W-1:0]         s_pixel_y,
    input  logic [brchs_pkg::VALUE_W-1:0]             s_pixel_value,
    input  logic signed [brchs_pkg::RECT_W-1:0]       s_rect_left,
    input  logic signed [brchs_pkg::RECT_W-1:0]       s_rect_top,
    input  logic signed [brchs_pkg::RECT_W-1:0]       s_rect_right,
    input  logic signed [brchs_pkg::RECT_W-1:0]       s_rect_bottom,
    // result channel
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic                                      m_hit,
    output logic [brchs_pkg::ROW_OUT_W-1:0]           m_hit_row
);

    import brchs_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN
    } state_t;

    // configuration registers
    logic [VALUE_W-1:0] key_color_reg;
    logic [SIZE_W-1:0]  image_width_reg;
    logic [SIZE_W-1:0]  image_height_reg;

    // sequencer and scan state
    state_t              state_reg, state_next;
    clip_t               sx_reg, sx_next, ex_reg, ex_next;
    clip_t               sy_reg, sy_next, ey_reg, ey_next;
    logic [XW-1:0]       c_reg, c_next;
    logic [YW-1:0]       r_reg, r_next;
    logic [AW-1:0]       base_reg, base_next;
    logic                pend_reg, pend_next;
    logic [YW-1:0]       pend_row_reg, pend_row_next;
    logic                done_iss_reg, done_iss_next;
    logic [ROW_OUT_W-1:0] last_hit_row_reg, last_hit_row_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_hit_reg, m_hit_next;
    logic [ROW_OUT_W-1:0] m_hit_row_reg, m_hit_row_next;

    // mask RAM connections
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_raddr;
    logic [COLOR_BITS-1:0] ram_rdata;

    logic                in_acc;
    logic                out_free;
    logic                load_in_range;
    logic [SAT_W-1:0]    w_sat, h_sat;
    clip_t               w_last, h_last;
    clip_t               left_c, top_c, right_c, bottom_c;
    logic                rect_empty;
    logic                pix_match;
    logic                last_col, last_row;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_color_reg    <= KEY_COLOR_RST;
            image_width_reg  <= SIZE_RST;
            image_height_reg <= SIZE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_KEY_COLOR:    key_color_reg    <= cfg_data;
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // image size saturated to 1..MAX
    always_comb begin
        w_sat = SAT_W'(image_width_reg);
        if (image_width_reg == '0) begin
            w_sat = SAT_W'(1);
        end else if (SAT_W'(image_width_reg) > SAT_W'(MAX_WIDTH)) begin
            w_sat = SAT_W'(MAX_WIDTH);
        end
        h_sat = SAT_W'(image_height_reg);
        if (image_height_reg == '0) begin
            h_sat = SAT_W'(1);
        end else if (SAT_W'(image_height_reg) > SAT_W'(MAX_HEIGHT)) begin
            h_sat = SAT_W'(MAX_HEIGHT);
        end
    end

    assign w_last = $signed(CLIP_W'(w_sat)) - clip_t'(1);
    assign h_last = $signed(CLIP_W'(h_sat)) - clip_t'(1);

    // clip the rectangle to the image
    assign left_c   = (s_rect_left < 0) ? clip_t'(0) : clip_t'(s_rect_left);
    assign top_c    = (s_rect_top < 0) ? clip_t'(0) : clip_t'(s_rect_top);
    assign right_c  = (clip_t'(s_rect_right) > w_last) ? w_last : clip_t'(s_rect_right);
    assign bottom_c = (clip_t'(s_rect_bottom) > h_last) ? h_last : clip_t'(s_rect_bottom);

    assign rect_empty = (sx_reg > ex_reg) || (sy_reg > ey_reg);

    assign in_acc        = s_valid && s_ready;
    assign out_free      = !m_valid_reg || m_ready;
    assign load_in_range = (SAT_W'(s_pixel_x) < SAT_W'(MAX_WIDTH))
                        && (SAT_W'(s_pixel_y) < SAT_W'(MAX_HEIGHT));
    assign pix_match     = (ram_rdata == key_color_reg[COLOR_BITS-1:0]);
    assign last_col      = (c_reg == ex_reg[XW-1:0]);
    assign last_row      = (r_reg == ey_reg[YW-1:0]);

    // load write port
    assign ram_we    = in_acc && (s_action == ACT_LOAD) && load_in_range;
    assign ram_waddr = AW'(s_pixel_y) * AW'(MAX_WIDTH) + AW'(s_pixel_x);

    // scan sequencer
    always_comb begin
        state_next        = state_reg;
        sx_next           = sx_reg;
        ex_next           = ex_reg;
        sy_next           = sy_reg;
        ey_next           = ey_reg;
        c_next            = c_reg;
        r_next            = r_reg;
        base_next         = base_reg;
        pend_next         = pend_reg;
        pend_row_next     = pend_row_reg;
        done_iss_next     = done_iss_reg;
        last_hit_row_next = last_hit_row_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_hit_next        = m_hit_reg;
        m_hit_row_next    = m_hit_row_reg;
        ram_rd_en         = 1'b0;
        ram_raddr         = base_reg + AW'(c_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && (s_action == ACT_QUERY)) begin
                    sx_next    = left_c;
                    ex_next    = right_c;
                    sy_next    = top_c;
                    ey_next    = bottom_c;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (rect_empty) begin
                    if (out_free) begin
                        m_valid_next   = 1'b1;
                        m_hit_next     = 1'b0;
                        m_hit_row_next = last_hit_row_reg;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    base_next     = AW'(sy_reg[YW-1:0]) * AW'(MAX_WIDTH);
                    c_next        = sx_reg[XW-1:0];
                    r_next        = sy_reg[YW-1:0];
                    pend_next     = 1'b0;
                    done_iss_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                priority if (pend_reg && pix_match) begin
                    // first key-colored pixel found
                    if (out_free) begin
                        m_valid_next      = 1'b1;
                        m_hit_next        = 1'b1;
                        m_hit_row_next    = ROW_OUT_W'(pend_row_reg);
                        last_hit_row_next = ROW_OUT_W'(pend_row_reg);
                        pend_next         = 1'b0;
                        state_next        = ST_IDLE;
                    end
                end else if (done_iss_reg) begin
                    // last pixel compared without a match
                    if (out_free) begin
                        m_valid_next   = 1'b1;
                        m_hit_next     = 1'b0;
                        m_hit_row_next = last_hit_row_reg;
                        pend_next      = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    // read the next pixel, compare it next cycle
                    ram_rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    pend_row_next = r_reg;
                    if (last_col) begin
                        if (last_row) begin
                            done_iss_next = 1'b1;
                        end else begin
                            c_next    = sx_reg[XW-1:0];
                            r_next    = r_reg + YW'(1);
                            base_next = base_reg + AW'(MAX_WIDTH);
                        end
                    end else begin
                        c_next = c_reg + XW'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            pend_reg         <= 1'b0;
            done_iss_reg     <= 1'b0;
            last_hit_row_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            pend_reg         <= pend_next;
            done_iss_reg     <= done_iss_next;
            last_hit_row_reg <= last_hit_row_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // scan payload registers
    always_ff @(posedge aclk) begin
        sx_reg        <= sx_next;
        ex_reg        <= ex_next;
        sy_reg        <= sy_next;
        ey_reg        <= ey_next;
        c_reg         <= c_next;
        r_reg         <= r_next;
        base_reg      <= base_next;
        pend_row_reg  <= pend_row_next;
        m_hit_reg     <= m_hit_next;
        m_hit_row_reg <= m_hit_row_next;
    end

    // mask store
    brchs_ram #(
        .WIDTH (COLOR_BITS),
        .DEPTH (DEPTH)
    ) u_mask_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (s_pixel_value[COLOR_BITS-1:0]),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_hit     = m_hit_reg;
    assign m_hit_row = m_hit_row_reg;

    // a fresh hit result carries the row that is kept
    a_hit_row_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) && m_hit_reg |-> m_hit_row_reg == last_hit_row_reg)
        else $error("hit row not kept");

    // once all reads are issued the last one is still pending compare
    a_done_has_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && done_iss_reg |-> pend_reg)
        else $error("scan finished without a pending compare");

    // reads stay inside the clipped rectangle
    a_read_in_rect: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_rd_en |-> (c_reg <= ex_reg[XW-1:0]) && (r_reg <= ey_reg[YW-1:0]))
        else $error("scan read outside rectangle");

endmodule
